// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
// No dependencies; included by files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// antecedent implies consequent in the same cycle
`define AST_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define AST_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ----- rtl/bbcw_pkg.sv -----
// Constants and types of the clipped-window box blur.
// No dependencies.
package bbcw_pkg;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MAX_RADIUS  = 7;
    localparam int STORE_DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int DIM_BITS    = 11;
    localparam int RAD_BITS    = 3;
    localparam int WIN_BITS    = $clog2(2 * MAX_RADIUS + 2);
    localparam int CNT_BITS    = 2 * WIN_BITS;
    localparam int RASTER_BITS = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;
    localparam int SUM_BITS    = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) * 255 + 1);
    localparam int Q_BITS      = 8;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_RADIUS = 2'd2,
        REG_NONE   = 2'd3
    } cfg_index_t;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;
endpackage

// ----- rtl/bbcw_pix_in_if.sv -----
// Input pixel channel: valid/ready plus op and RGBA payload.
// No dependencies.
interface bbcw_pix_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
    modport source (output valid, op, in_red, in_green, in_blue, in_alpha, input ready);
    modport sink (input valid, op, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

// ----- rtl/bbcw_pix_out_if.sv -----
// Output pixel channel: valid/ready plus RGBA means and frame_done.
// No dependencies.
interface bbcw_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       frame_done;
    modport source (output valid, out_red, out_green, out_blue, out_alpha, frame_done,
                    input ready);
    modport sink (input valid, out_red, out_green, out_blue, out_alpha, frame_done,
                  output ready);
endinterface

// ----- rtl/bbcw_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bbcw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/box_blur_clipped_window.sv -----
// Channel    | dir | handshake          | payload
// pix_in     | in  | valid & ready      | op, in_red/green/blue/alpha
// pix_out    | out | valid & ready      | out_red/green/blue/alpha, frame_done
// cfg        | in  | cfg_we             | cfg_index, cfg_data
// An item with no result leaves the block idle. An item that releases a result
// passes through the accept, dy + 1 setup steps for the window corner, one
// line-store read per window pixel, the last read, 8 divider steps and the load
// of the result, which waits while the output register is full and not taken.
// The line store keeps no reset; only counters and control reset.
// A finished result waits in the output register; a new item is taken meanwhile
// and stalls only before its own result is loaded.
// Depends on bbcw_pkg, the channel interfaces, bbcw_ram and assert_macros.svh.
`include "assert_macros.svh"
module box_blur_clipped_window (
    input  logic                         clk,
    input  logic                         rst_n,
    bbcw_pix_in_if.sink                  pix_in,
    bbcw_pix_out_if.source               pix_out,
    input  logic                         cfg_we,
    input  bbcw_pkg::cfg_index_t         cfg_index,
    input  logic [bbcw_pkg::DIM_BITS-1:0] cfg_data
);
    import bbcw_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SETUP = 6'b000010,
        ST_READ  = 6'b000100,
        ST_LAST  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [DIM_BITS-1:0] width_reg, height_reg;
    logic [RAD_BITS-1:0] radius_reg;
    logic [DIM_BITS-1:0] eff_w, eff_h;
    logic [RAD_BITS-1:0] eff_r;

    always_comb
    begin
        eff_w = (width_reg == '0) ? DIM_BITS'(1)
              : (width_reg > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH) : width_reg;
        eff_h = (height_reg == '0) ? DIM_BITS'(1)
              : (height_reg > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT) : height_reg;
        eff_r = (radius_reg > RAD_BITS'(MAX_RADIUS)) ? RAD_BITS'(MAX_RADIUS) : radius_reg;
    end

    // frame position counters
    logic [COL_BITS-1:0]    in_col_reg, out_col_reg;
    logic [ROW_BITS-1:0]    in_row_reg, out_row_reg;
    logic                   in_done_reg;
    logic [RASTER_BITS-1:0] n_reg, m_reg;
    logic [ADDR_BITS-1:0]   in_addr_reg, out_addr_reg;

    // window walk
    logic [ADDR_BITS-1:0] cur_addr_reg, row_addr_reg;
    logic [WIN_BITS-1:0]  sub_cnt_reg, x_reg, y_reg, cols_reg, rows_reg;
    logic                 rd_valid_reg;
    logic [SUM_BITS-1:0]  sum_reg [4];
    logic [SUM_BITS-1:0]  div_reg;
    logic [Q_BITS-1:0]    q_reg [4];
    logic [2:0]           step_reg;
    logic [31:0]          rdata;

    // output register
    logic       out_valid_reg;
    logic [7:0] out_px_reg [4];
    logic       out_last_reg;

    // modular address helpers
    function automatic logic [ADDR_BITS-1:0] addr_sub(input logic [ADDR_BITS-1:0] a,
                                                      input logic [ADDR_BITS:0] d);
        logic [ADDR_BITS:0] t;
        t = {1'b0, a} + ADDR_BITS'(STORE_DEPTH) - d;
        if (t >= (ADDR_BITS+1)'(STORE_DEPTH))
        begin
            t = t - (ADDR_BITS+1)'(STORE_DEPTH);
        end
        return t[ADDR_BITS-1:0];
    endfunction

    function automatic logic [ADDR_BITS-1:0] addr_add(input logic [ADDR_BITS-1:0] a,
                                                      input logic [ADDR_BITS:0] d);
        logic [ADDR_BITS:0] t;
        t = {1'b0, a} + d;
        if (t >= (ADDR_BITS+1)'(STORE_DEPTH))
        begin
            t = t - (ADDR_BITS+1)'(STORE_DEPTH);
        end
        return t[ADDR_BITS-1:0];
    endfunction

    logic [ADDR_BITS:0] w_ext;
    assign w_ext = (ADDR_BITS+1)'(eff_w);

    // window extent of the pending output, clipped to the frame
    logic [DIM_BITS-1:0] orow, ocol, dy, dx, y1, x1, hi_r, hi_c;
    logic [WIN_BITS-1:0] rows, cols;
    logic [CNT_BITS-1:0] cnt;

    always_comb
    begin
        orow = DIM_BITS'(out_row_reg);
        ocol = DIM_BITS'(out_col_reg);
        dy   = (orow > DIM_BITS'(eff_r)) ? DIM_BITS'(eff_r) : orow;
        dx   = (ocol > DIM_BITS'(eff_r)) ? DIM_BITS'(eff_r) : ocol;
        hi_r = orow + DIM_BITS'(eff_r);
        hi_c = ocol + DIM_BITS'(eff_r);
        y1   = (hi_r > eff_h - 1'b1) ? eff_h - 1'b1 : hi_r;
        x1   = (hi_c > eff_w - 1'b1) ? eff_w - 1'b1 : hi_c;
        rows = WIN_BITS'(y1 - (orow - dy) + 1'b1);
        cols = WIN_BITS'(x1 - (ocol - dx) + 1'b1);
        cnt  = CNT_BITS'(rows) * CNT_BITS'(cols);
    end

    // emission test: pending output index plus lag reaches the newest pixel
    logic [RASTER_BITS:0] lag, m_plus_lag;
    logic accept, store_we, go;

    assign lag        = (RASTER_BITS+1)'(eff_r) * (RASTER_BITS+1)'(eff_w)
                      + (RASTER_BITS+1)'(eff_r);
    assign m_plus_lag = {1'b0, m_reg} + lag;
    assign accept     = pix_in.valid && pix_in.ready;
    assign store_we   = accept && (pix_in.op == OP_PIXEL) && !in_done_reg;
    assign go = accept && (((pix_in.op == OP_DRAIN) && in_done_reg)
                           || (store_we && (m_plus_lag <= {1'b0, n_reg})));
    assign pix_in.ready = (state_reg == ST_IDLE);

    logic last_px;
    assign last_px = (orow == eff_h - 1'b1) && (ocol == eff_w - 1'b1);

    bbcw_ram #(
        .WIDTH(32),
        .DEPTH(STORE_DEPTH)
    ) u_line_store (
        .clk  (clk),
        .we   (store_we),
        .waddr(in_addr_reg),
        .wdata({pix_in.in_alpha, pix_in.in_blue, pix_in.in_green, pix_in.in_red}),
        .raddr(cur_addr_reg),
        .rdata(rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (go) state_next = ST_SETUP;
            ST_SETUP: if (sub_cnt_reg == '0) state_next = ST_READ;
            ST_READ:  if (x_reg == cols_reg - 1'b1 && y_reg == rows_reg - 1'b1)
                          state_next = ST_LAST;
            ST_LAST:  state_next = ST_DIV;
            ST_DIV:   if (step_reg == '0) state_next = ST_DONE;
            ST_DONE:  if (!out_valid_reg || pix_out.ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    logic load_out;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || pix_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= DIM_BITS'(MAX_WIDTH);
            height_reg    <= DIM_BITS'(MAX_HEIGHT);
            radius_reg    <= '0;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            in_done_reg   <= 1'b0;
            n_reg         <= '0;
            m_reg         <= '0;
            in_addr_reg   <= '0;
            out_addr_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == ST_READ);
            if (pix_out.valid && pix_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (store_we)
            begin
                n_reg       <= n_reg + 1'b1;
                in_addr_reg <= addr_add(in_addr_reg, (ADDR_BITS+1)'(1));
                if (DIM_BITS'(in_col_reg) + 1'b1 >= eff_w)
                begin
                    in_col_reg <= '0;
                    if (DIM_BITS'(in_row_reg) + 1'b1 >= eff_h)
                        in_done_reg <= 1'b1;
                    else
                        in_row_reg <= in_row_reg + 1'b1;
                end
                else
                begin
                    in_col_reg <= in_col_reg + 1'b1;
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                if (last_px)
                begin
                    // frame end: every counter starts over
                    in_col_reg   <= '0;
                    in_row_reg   <= '0;
                    out_col_reg  <= '0;
                    out_row_reg  <= '0;
                    in_done_reg  <= 1'b0;
                    n_reg        <= '0;
                    m_reg        <= '0;
                    in_addr_reg  <= '0;
                    out_addr_reg <= '0;
                end
                else
                begin
                    m_reg        <= m_reg + 1'b1;
                    out_addr_reg <= addr_add(out_addr_reg, (ADDR_BITS+1)'(1));
                    if (ocol + 1'b1 >= eff_w)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + 1'b1;
                    end
                end
            end
            if (cfg_we && cfg_index != REG_NONE)
            begin
                unique case (cfg_index)
                    REG_WIDTH:  width_reg  <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    REG_RADIUS: radius_reg <= cfg_data[RAD_BITS-1:0];
                    default:    ;
                endcase
                // any write to width, height or radius aborts the frame; store contents stay
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                in_done_reg  <= 1'b0;
                n_reg        <= '0;
                m_reg        <= '0;
                in_addr_reg  <= '0;
                out_addr_reg <= '0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && go)
        begin
            cur_addr_reg <= addr_sub(out_addr_reg, (ADDR_BITS+1)'(dx));
            sub_cnt_reg  <= WIN_BITS'(dy);
            rows_reg     <= rows;
            cols_reg     <= cols;
            x_reg        <= '0;
            y_reg        <= '0;
            div_reg      <= SUM_BITS'({cnt, 7'b0});
            step_reg     <= 3'd7;
            for (int k = 0; k < 4; k++)
            begin
                sum_reg[k] <= '0;
            end
        end
        if (state_reg == ST_SETUP)
        begin
            if (sub_cnt_reg != '0)
            begin
                cur_addr_reg <= addr_sub(cur_addr_reg, w_ext);
                sub_cnt_reg  <= sub_cnt_reg - 1'b1;
            end
            else
            begin
                row_addr_reg <= cur_addr_reg;
            end
        end
        if (state_reg == ST_READ)
        begin
            if (x_reg == cols_reg - 1'b1)
            begin
                x_reg        <= '0;
                y_reg        <= y_reg + 1'b1;
                row_addr_reg <= addr_add(row_addr_reg, w_ext);
                cur_addr_reg <= addr_add(row_addr_reg, w_ext);
            end
            else
            begin
                x_reg        <= x_reg + 1'b1;
                cur_addr_reg <= addr_add(cur_addr_reg, (ADDR_BITS+1)'(1));
            end
        end
        if (rd_valid_reg)
        begin
            for (int k = 0; k < 4; k++)
            begin
                sum_reg[k] <= sum_reg[k] + SUM_BITS'(rdata[8*k +: 8]);
            end
        end
        if (state_reg == ST_DIV)
        begin
            // restoring division, one quotient bit per cycle
            for (int k = 0; k < 4; k++)
            begin
                if (sum_reg[k] >= div_reg)
                begin
                    sum_reg[k] <= sum_reg[k] - div_reg;
                    q_reg[k]   <= {q_reg[k][Q_BITS-2:0], 1'b1};
                end
                else
                begin
                    q_reg[k] <= {q_reg[k][Q_BITS-2:0], 1'b0};
                end
            end
            div_reg  <= div_reg >> 1;
            step_reg <= step_reg - 1'b1;
        end
        if (load_out)
        begin
            for (int k = 0; k < 4; k++)
            begin
                out_px_reg[k] <= q_reg[k];
            end
            out_last_reg <= last_px;
        end
    end

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.out_red    = out_px_reg[0];
    assign pix_out.out_green  = out_px_reg[1];
    assign pix_out.out_blue   = out_px_reg[2];
    assign pix_out.out_alpha  = out_px_reg[3];
    assign pix_out.frame_done = out_last_reg;

    `AST_IMPLY(a_rd_in_walk, clk, rst_n, rd_valid_reg,
               (state_reg == ST_READ || state_reg == ST_LAST))
    `AST_IMPLY(a_done_col_zero, clk, rst_n, in_done_reg, (in_col_reg == '0))
    `AST_NEXT(a_load_sets_valid, clk, rst_n, load_out, out_valid_reg)
endmodule
